/* design/iterated_prime_count_engine_top_defines.svh */
// assertion helpers for the iterated prime-count engine
`ifndef ITERATED_PRIME_COUNT_ENGINE_TOP_DEFINES_SVH
`define ITERATED_PRIME_COUNT_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IPCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define IPCE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ipce_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipce_pkg
// shared types for the iterated prime-count engine: sequencer states and
// the command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package ipce_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_MARK,
		ST_IDLE,
		ST_LOOK_RD,
		ST_LOOK_CHK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic scan_chk;
		logic mark;
		logic adv;
		logic load;
		logic look;
		logic look_chk;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic flag;
		logic j_over;
		logic iter_zero;
		logic step_end;
		logic out_free;
	} sts_t;

endpackage

/* design/ipce_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipce_ctrl
// sequencer: clears and sieves the flag table, fills the count table, then
// serves queries one at a time through repeated count-table lookups
// ----------------------------------------------------------------------------
module ipce_ctrl
	import ipce_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sts_t sts,
	output logic in_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.idx_last) state_nxt = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				state_nxt = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				priority if (sts.flag) state_nxt = ST_MARK;
				else if (sts.idx_last) state_nxt = ST_IDLE;
				else state_nxt = ST_SCAN_RD;
			end
			ST_MARK: begin
				if (sts.j_over) state_nxt = sts.idx_last ? ST_IDLE : ST_SCAN_RD;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_LOOK_RD;
			end
			ST_LOOK_RD: begin
				state_nxt = sts.iter_zero ? ST_FINISH : ST_LOOK_CHK;
			end
			ST_LOOK_CHK: begin
				state_nxt = sts.step_end ? ST_FINISH : ST_LOOK_RD;
			end
			ST_FINISH: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR:    cmd.clr_wr = 1'b1;
			ST_SCAN_RD:  cmd = '0;
			ST_SCAN_CHK: begin
				cmd.scan_chk = 1'b1;
				cmd.adv      = !sts.flag;
			end
			ST_MARK: begin
				cmd.mark = !sts.j_over;
				cmd.adv  = sts.j_over;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_LOOK_RD:  cmd.look = 1'b1;
			ST_LOOK_CHK: cmd.look_chk = 1'b1;
			ST_FINISH:   cmd.finish = sts.out_free;
			default:     cmd = '0;
		endcase
	end

endmodule

/* design/ipce_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipce_datapath
// flag and count memories, sieve index and stride counters, query value
// and iteration registers, and the output register
// ----------------------------------------------------------------------------
module ipce_datapath
	import ipce_pkg::*;
#(
	parameter int MAX_VALUE = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [DATA_W-1:0] iterations,
	input  logic [DATA_W-1:0] start_value,
	input  logic              out_ready,
	output sts_t              sts,
	output logic              out_valid,
	output logic [DATA_W-1:0] final_value
);

	localparam int AW = $clog2(MAX_VALUE + 1);
	// a prime count never exceeds the value it counts up to
	localparam int CW = AW;

	logic          flag_mem [0:MAX_VALUE];
	logic [CW-1:0] cnt_mem  [0:MAX_VALUE];

	logic [AW-1:0]     idx_q;
	logic [AW:0]       j_q;
	logic [CW-1:0]     run_q;
	logic              flag_rd_q;
	logic [CW-1:0]     cnt_rd_q;
	logic [DATA_W-1:0] iter_q;
	logic [DATA_W-1:0] val_q;
	logic              small_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] final_q;

	logic              flag_we;
	logic [AW-1:0]     flag_wa;
	logic              flag_wd;
	logic [CW-1:0]     run_nxt;
	logic [AW-1:0]     look_addr;
	logic [DATA_W-1:0] step_val;

	assign flag_we   = cmd.clr_wr | cmd.mark;
	assign flag_wa   = cmd.mark ? j_q[AW-1:0] : idx_q;
	// clear pass marks everything from two upward as a prime candidate
	assign flag_wd   = cmd.clr_wr & (idx_q > AW'(1));
	assign run_nxt   = run_q + CW'(flag_rd_q);
	assign look_addr = (val_q > DATA_W'(MAX_VALUE)) ? AW'(MAX_VALUE) : val_q[AW-1:0];
	assign step_val  = small_q ? DATA_W'(1) : DATA_W'(cnt_rd_q);

	always_ff @(posedge clk) begin
		if (flag_we) flag_mem[flag_wa] <= flag_wd;
		flag_rd_q <= flag_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_chk) cnt_mem[idx_q] <= run_nxt;
		cnt_rd_q <= cnt_mem[look_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			j_q   <= '0;
			run_q <= '0;
		end else begin
			if (cmd.clr_wr) begin
				idx_q <= sts.idx_last ? '0 : idx_q + AW'(1);
			end else if (cmd.adv) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.scan_chk) begin
				run_q <= run_nxt;
				j_q   <= {idx_q, 1'b0};
			end else if (cmd.mark) begin
				j_q <= j_q + {1'b0, idx_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			iter_q <= iterations;
			val_q  <= start_value;
		end else if (cmd.look_chk) begin
			iter_q <= iter_q - DATA_W'(1);
			val_q  <= step_val;
		end
		if (cmd.look) small_q <= (val_q <= DATA_W'(1));
		if (cmd.finish) final_q <= val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.idx_last  = (idx_q == AW'(MAX_VALUE));
		sts.flag      = flag_rd_q;
		sts.j_over    = (j_q > (AW + 1)'(MAX_VALUE));
		sts.iter_zero = (iter_q == '0);
		sts.step_end  = (iter_q == DATA_W'(1)) || (step_val <= DATA_W'(2));
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign final_value = final_q;

endmodule

/* design/iterated_prime_count_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterated_prime_count_engine_top
// iterates the prime-count function over a query value using a sieve-built
// count table
// ----------------------------------------------------------------------------
//  channel  dir  beat fields                handshake
//  in       in   iterations, start_value    in_valid / in_ready
//  out      out  final_value                out_valid / out_ready
//
// after reset the table build runs: a clear pass over all MAX_VALUE+1 flags,
// a scan of each value, and per prime a pass marking each of its multiples;
// in_ready stays low.
// a query makes k >= 1 count-table lookups, none with zero iterations
// (k is about 8 at the default size), each waiting on the count-table read
// with its registered data.
// a result parks in the output register; the next beat is taken meanwhile
// and its result waits in the finish step only while out_ready is low.
`include "iterated_prime_count_engine_top_defines.svh"

module iterated_prime_count_engine_top
	import ipce_pkg::*;
#(
	parameter int MAX_VALUE = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] iterations,
	input  logic [DATA_W-1:0] start_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] final_value
);

	cmd_t cmd;
	sts_t sts;

	ipce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	ipce_datapath #(
		.MAX_VALUE (MAX_VALUE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.iterations  (iterations),
		.start_value (start_value),
		.out_ready   (out_ready),
		.sts         (sts),
		.out_valid   (out_valid),
		.final_value (final_value)
	);

	// one query in flight: an accepted beat drops ready
	`IPCE_ASSERT_NXT(a_one_query, in_valid && in_ready, !in_ready, "ready after accept")
	// a finished result always lands in the output register
	`IPCE_ASSERT_NXT(a_finish_out, cmd.finish, out_valid && final_value == $past(u_dp.val_q), "result lost")
	// the output register is never overwritten while still held
	`IPCE_ASSERT_IMP(a_no_clobber, cmd.finish, !out_valid || out_ready, "output overwritten")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the iterated prime-count engine against its own sieve-built count
// table: directed corner queries, then bursty random queries, while the
// result side stalls on a changing pattern
// ----------------------------------------------------------------------------
module testbench;
	import ipce_pkg::*;

	localparam int PI_MAX = 65536;
	localparam int QUERY_TOTAL = 1350;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 60;

	// expected final values, predicted from a local prime-count table
	class pi_iter_tracker;
		int unsigned pi_table [0:PI_MAX];
		bit [DATA_W-1:0] pending_values [$];
		int fail_count;

		function new();
			bit composite [0:PI_MAX];
			int unsigned running;
			for (int i = 0; i <= PI_MAX; i++)
				composite[i] = 1'b0;
			for (int i = 2; i * i <= PI_MAX; i++) begin
				if (!composite[i]) begin
					for (int j = i * i; j <= PI_MAX; j += i)
						composite[j] = 1'b1;
				end
			end
			running = 0;
			pi_table[0] = 0;
			for (int i = 1; i <= PI_MAX; i++) begin
				if (i >= 2 && !composite[i])
					running++;
				pi_table[i] = running;
			end
			fail_count = 0;
		endfunction

		function bit [DATA_W-1:0] iterate_pi(bit [DATA_W-1:0] iters, bit [DATA_W-1:0] v);
			longint unsigned n;
			bit stopped;
			stopped = 1'b0;
			for (n = 0; n < iters && !stopped; n++) begin
				if (v <= 1)
					v = 1;
				else if (v > PI_MAX)
					v = pi_table[PI_MAX];
				else
					v = pi_table[v];
				// once at 2 or below the engine stops iterating
				if (v <= 2)
					stopped = 1'b1;
			end
			return v;
		endfunction

		function void note_query(bit [DATA_W-1:0] iters, bit [DATA_W-1:0] start);
			pending_values.push_back(iterate_pi(iters, start));
		endfunction

		function void check_final(bit [DATA_W-1:0] got);
			bit [DATA_W-1:0] want;
			if (pending_values.size() == 0) begin
				$error("final_value: no query pending, got %0d", got);
				fail_count++;
			end else begin
				want = pending_values.pop_front();
				if (got !== want) begin
					$error("final_value: expected %0d, got %0d", want, got);
					fail_count++;
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [DATA_W-1:0] iterations = '0;
	logic [DATA_W-1:0] start_value = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [DATA_W-1:0] final_value;

	pi_iter_tracker board = new();
	longint cycle_count = 0;
	int unsigned ready_mode = 0;
	int unsigned stall_left = 0;

	iterated_prime_count_engine_top #(
		.MAX_VALUE(PI_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.iterations(iterations),
		.start_value(start_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.final_value(final_value)
	);

	always #5 clk = ~clk;

	// beat monitor: both channels sampled on the edge that accepts them
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_final(final_value);
			if (in_valid && in_ready)
				board.note_query(iterations, start_value);
		end
	end

	// result side: out_ready follows a stall pattern picked at random from four modes
	always @(posedge clk) begin
		bit nxt_ready;
		nxt_ready = 1'b1;
		if (cycle_count % 512 == 0)
			ready_mode <= $urandom_range(0, 3);
		if (stall_left > 0) begin
			nxt_ready = 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			case (ready_mode)
				0: nxt_ready = 1'b1;
				1: nxt_ready = $urandom_range(0, 1);
				2: nxt_ready = ($urandom_range(0, 3) == 0);
				default: begin
					nxt_ready = 1'b1;
					if ($urandom_range(0, 7) == 0)
						stall_left <= $urandom_range(1, 20);
				end
			endcase
		end
		out_ready <= nxt_ready;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL iterated_prime_count_engine_top");
			$finish;
		end
	end

	task automatic send_query(input bit [DATA_W-1:0] iters, input bit [DATA_W-1:0] start);
		in_valid <= 1'b1;
		iterations <= iters;
		start_value <= start;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic hold_off(input int unsigned n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic bit [DATA_W-1:0] pick_iterations();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return 0;
		else if (r < 6)
			return $urandom_range(1, 4);
		else if (r < 8)
			return $urandom_range(5, 40);
		return $urandom();
	endfunction

	function automatic bit [DATA_W-1:0] pick_start();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom_range(0, PI_MAX + 2);
		else if (r < 6)
			return $urandom_range(0, 40);
		else if (r < 7)
			return $urandom_range(PI_MAX - 4, PI_MAX + 4);
		return $urandom();
	endfunction

	initial begin
		int sent;
		int unsigned burst_len;
		bit drained;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// first beat is offered while the table is still being built
		send_query(0, 0);
		send_query(0, 32'hFFFF_FFFF);
		send_query(1, 0);
		send_query(1, 1);
		send_query(1, 2);
		send_query(1, 3);
		send_query(1, 4);
		send_query(1, PI_MAX - 1);
		send_query(1, PI_MAX);
		send_query(1, PI_MAX + 1);
		send_query(1, 32'hFFFF_FFFF);
		send_query(2, PI_MAX);
		send_query(3, 1000000);
		send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_query(32'hFFFF_FFFF, 0);
		send_query(32'hFFFF_FFFF, 100);
		send_query(5, 32'h8000_0000);
		send_query(32'h8000_0000, 12345);
		send_query(2, 30);
		send_query(0, 12345);

		sent = 0;
		drained = 1'b0;
		while (sent < QUERY_TOTAL) begin
			burst_len = $urandom_range(1, 24);
			for (int k = 0; k < burst_len && sent < QUERY_TOTAL; k++) begin
				send_query(pick_iterations(), pick_start());
				sent++;
			end
			if (!drained && sent >= QUERY_TOTAL / 2) begin
				// let every pending result come out before going on
				in_valid <= 1'b0;
				// let the monitor note the last beat before the queue is checked
				@(posedge clk);
				while (board.pending_values.size() != 0)
					@(posedge clk);
				drained = 1'b1;
			end else if ($urandom_range(0, 3) != 0) begin
				hold_off($urandom_range(1, 8));
			end
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (board.pending_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fail_count == 0 && board.pending_values.size() == 0)
			$display("PASS iterated_prime_count_engine_top");
		else
			$display("FAIL iterated_prime_count_engine_top");
		$finish;
	end

endmodule
